// File: hdl/ipc_pkg.sv
// Shared types and constants for the multi-channel interval profiler.
`default_nettype none

package ipc_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int TS_W = 32;
    localparam int CNT_W = 64;
    localparam int MASK_W = 16;
    localparam int CH_W = 4;
    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] CMD_ENTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

    typedef struct packed {
        logic            busy;
        logic [TS_W-1:0] start_time;
        logic [TS_W-1:0] isr_start;
        logic [TS_W-1:0] error_count;
    } ctl_t;

    typedef struct packed {
        logic [TS_W-1:0]  min_elapsed;
        logic [TS_W-1:0]  max_elapsed;
        logic [TS_W-1:0]  max_elapsed_with_isr;
        logic [CNT_W-1:0] call_count;
        logic [CNT_W-1:0] total_elapsed;
        logic [CNT_W-1:0] total_elapsed_with_isr;
    } stat_t;

    localparam ctl_t CTL_RESET = '{
        busy: 1'b0,
        start_time: '0,
        isr_start: '0,
        error_count: '0
    };

    localparam stat_t STAT_RESET = '{
        min_elapsed: '1,
        max_elapsed: '0,
        max_elapsed_with_isr: '0,
        call_count: '0,
        total_elapsed: '0,
        total_elapsed_with_isr: '0
    };

endpackage

`default_nettype wire

// File: hdl/interval_profiler_channels_top.sv
// Multi-channel interval profiler: per-channel statistics in two memories.
//
// A command is taken when start is high and busy is low. Each command passes in turn
// through these steps: the channel entry is read from the memories, the elapsed and
// interrupt times are formed, then the entry is updated and written back while the
// result is registered. The result word shows on the result ports for one cycle with
// done high after the write-back, and cannot be held off by the receiver. A new command
// may be started in the same cycle that done is high; none is taken while busy is high.
// The clear command resets all channel statistics at once through per-channel valid
// bits, so it takes no longer than any other command.
`default_nettype none

module interval_profiler_channels_top #(
    parameter int CHANNELS = ipc_pkg::CHANNELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ipc_pkg::CMD_W-1:0]   command,
    input  wire logic [ipc_pkg::CH_W-1:0]    channel,
    input  wire logic [ipc_pkg::TS_W-1:0]    timestamp,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ipc_pkg::MASK_W-1:0]  cfg_wr_data,
    output logic                             done,
    output logic                             status,
    output logic                             running,
    output logic [ipc_pkg::CNT_W-1:0]        call_count,
    output logic [ipc_pkg::TS_W-1:0]         error_count,
    output logic [ipc_pkg::TS_W-1:0]         min_elapsed,
    output logic [ipc_pkg::TS_W-1:0]         max_elapsed,
    output logic [ipc_pkg::TS_W-1:0]         max_elapsed_with_isr,
    output logic [ipc_pkg::CNT_W-1:0]        total_elapsed,
    output logic [ipc_pkg::CNT_W-1:0]        total_elapsed_with_isr
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic accept;
    logic [ADDR_W+ipc_pkg::CH_W-1:0] ch_wide;
    logic [ADDR_W-1:0] addr;
    logic in_range;

    logic [ipc_pkg::CMD_W-1:0] cmd_reg;
    logic [ipc_pkg::CH_W-1:0] ch_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ipc_pkg::TS_W-1:0] ts_reg;
    logic in_range_reg;

    ipc_pkg::ctl_t ctl_mem [CHANNELS];
    ipc_pkg::stat_t stat_mem [CHANNELS];
    ipc_pkg::ctl_t ctl_rd_reg;
    ipc_pkg::stat_t stat_rd_reg;
    logic [CHANNELS-1:0] ctl_valid_reg;
    logic [CHANNELS-1:0] stat_valid_reg;

    ipc_pkg::ctl_t ctl_cur;
    ipc_pkg::stat_t stat_cur;
    ipc_pkg::ctl_t ctl_wdata;
    ipc_pkg::stat_t stat_wdata;
    logic ctl_we;
    logic stat_we;

    logic [ipc_pkg::MASK_W-1:0] mask_reg;
    logic [ipc_pkg::TS_W-1:0] isr_total_reg;
    logic [ipc_pkg::TS_W-1:0] isr_total_next;
    logic [ipc_pkg::TS_W-1:0] el_reg;
    logic [ipc_pkg::TS_W-1:0] delta_reg;
    logic [ipc_pkg::TS_W-1:0] el_net;
    logic status_next;

    logic done_reg;
    logic status_reg;
    ipc_pkg::ctl_t ctl_out_reg;
    ipc_pkg::stat_t stat_out_reg;

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign ch_wide = {{ADDR_W{1'b0}}, channel};
    assign addr = ch_wide[ADDR_W-1:0];
    assign in_range = ({28'd0, channel} < 32'(CHANNELS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= ipc_pkg::CMD_READ;
            ch_reg <= '0;
            addr_reg <= '0;
            ts_reg <= '0;
            in_range_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_reg <= command;
            ch_reg <= channel;
            addr_reg <= addr;
            ts_reg <= timestamp;
            in_range_reg <= in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_rd_reg <= ctl_mem[addr];
            stat_rd_reg <= stat_mem[addr];
        end
        if (ctl_we)
        begin
            ctl_mem[addr_reg] <= ctl_wdata;
        end
        if (stat_we)
        begin
            stat_mem[addr_reg] <= stat_wdata;
        end
    end

    assign ctl_cur = ctl_valid_reg[addr_reg] ? ctl_rd_reg : ipc_pkg::CTL_RESET;
    assign stat_cur = stat_valid_reg[addr_reg] ? stat_rd_reg : ipc_pkg::STAT_RESET;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            el_reg <= ts_reg - ctl_cur.start_time;
            delta_reg <= isr_total_reg - ctl_cur.isr_start;
        end
    end

    assign el_net = el_reg - delta_reg;

    always_comb
    begin
        ctl_wdata = ctl_cur;
        stat_wdata = stat_cur;
        status_next = 1'b0;
        isr_total_next = isr_total_reg;
        unique case (cmd_reg)
            ipc_pkg::CMD_ENTER:
            begin
                if (!ctl_cur.busy)
                begin
                    ctl_wdata.busy = 1'b1;
                    ctl_wdata.start_time = ts_reg;
                    ctl_wdata.isr_start = isr_total_reg;
                end
                else
                begin
                    ctl_wdata.error_count = ctl_cur.error_count + 32'd1;
                    status_next = 1'b1;
                end
            end
            ipc_pkg::CMD_EXIT:
            begin
                if (ctl_cur.busy)
                begin
                    if (el_reg > stat_cur.max_elapsed_with_isr)
                    begin
                        stat_wdata.max_elapsed_with_isr = el_reg;
                    end
                    stat_wdata.total_elapsed_with_isr =
                        stat_cur.total_elapsed_with_isr + {32'd0, el_reg};
                    if (mask_reg[ch_reg])
                    begin
                        isr_total_next = isr_total_reg + el_net;
                    end
                    if (el_net < stat_cur.min_elapsed)
                    begin
                        stat_wdata.min_elapsed = el_net;
                    end
                    if (el_net > stat_cur.max_elapsed)
                    begin
                        stat_wdata.max_elapsed = el_net;
                    end
                    stat_wdata.total_elapsed = stat_cur.total_elapsed + {32'd0, el_net};
                    stat_wdata.call_count = stat_cur.call_count + 64'd1;
                    ctl_wdata.busy = 1'b0;
                end
                else
                begin
                    ctl_wdata.error_count = ctl_cur.error_count + 32'd1;
                    status_next = 1'b1;
                end
            end
            ipc_pkg::CMD_CLEAR:
            begin
                stat_wdata = ipc_pkg::STAT_RESET;
            end
            ipc_pkg::CMD_READ:
            begin
            end
        endcase
    end

    assign ctl_we = (state_reg == ST_WRITE) && in_range_reg;
    assign stat_we = (state_reg == ST_WRITE) && in_range_reg && (cmd_reg != ipc_pkg::CMD_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_valid_reg <= '0;
            stat_valid_reg <= '0;
            isr_total_reg <= '0;
            mask_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_WRITE);
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (ctl_we)
            begin
                ctl_valid_reg[addr_reg] <= 1'b1;
                isr_total_reg <= isr_total_next;
            end
            if (state_reg == ST_WRITE && in_range_reg && cmd_reg == ipc_pkg::CMD_CLEAR)
            begin
                stat_valid_reg <= '0;
            end
            else if (stat_we)
            begin
                stat_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            if (in_range_reg)
            begin
                status_reg <= status_next;
                ctl_out_reg <= ctl_wdata;
                stat_out_reg <= stat_wdata;
            end
            else
            begin
                status_reg <= 1'b0;
                ctl_out_reg <= '0;
                stat_out_reg <= '0;
            end
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign running = ctl_out_reg.busy;
    assign call_count = stat_out_reg.call_count;
    assign error_count = ctl_out_reg.error_count;
    assign min_elapsed = stat_out_reg.min_elapsed;
    assign max_elapsed = stat_out_reg.max_elapsed;
    assign max_elapsed_with_isr = stat_out_reg.max_elapsed_with_isr;
    assign total_elapsed = stat_out_reg.total_elapsed;
    assign total_elapsed_with_isr = stat_out_reg.total_elapsed_with_isr;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the multi-channel interval profiler top level.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = ipc_pkg::CHANNELS_DEF;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic                      status;
        logic                      running;
        logic [ipc_pkg::CNT_W-1:0] call_count;
        logic [ipc_pkg::TS_W-1:0]  error_count;
        logic [ipc_pkg::TS_W-1:0]  min_elapsed;
        logic [ipc_pkg::TS_W-1:0]  max_elapsed;
        logic [ipc_pkg::TS_W-1:0]  max_elapsed_with_isr;
        logic [ipc_pkg::CNT_W-1:0] total_elapsed;
        logic [ipc_pkg::CNT_W-1:0] total_elapsed_with_isr;
    } chan_stats_t;

    typedef struct {
        bit                         is_cfg;
        logic [ipc_pkg::CMD_W-1:0]  cmd;
        logic [ipc_pkg::CH_W-1:0]   ch;
        logic [ipc_pkg::TS_W-1:0]   ts;
        logic [ipc_pkg::MASK_W-1:0] mask;
    } pending_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [ipc_pkg::CMD_W-1:0] command;
    logic [ipc_pkg::CH_W-1:0] channel;
    logic [ipc_pkg::TS_W-1:0] timestamp;
    logic cfg_wr_en;
    logic [ipc_pkg::MASK_W-1:0] cfg_wr_data;
    logic done;
    logic status;
    logic running;
    logic [ipc_pkg::CNT_W-1:0] call_count;
    logic [ipc_pkg::TS_W-1:0] error_count;
    logic [ipc_pkg::TS_W-1:0] min_elapsed;
    logic [ipc_pkg::TS_W-1:0] max_elapsed;
    logic [ipc_pkg::TS_W-1:0] max_elapsed_with_isr;
    logic [ipc_pkg::CNT_W-1:0] total_elapsed;
    logic [ipc_pkg::CNT_W-1:0] total_elapsed_with_isr;

    interval_profiler_channels_top #(.CHANNELS(NCH)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .channel(channel),
        .timestamp(timestamp),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done(done),
        .status(status),
        .running(running),
        .call_count(call_count),
        .error_count(error_count),
        .min_elapsed(min_elapsed),
        .max_elapsed(max_elapsed),
        .max_elapsed_with_isr(max_elapsed_with_isr),
        .total_elapsed(total_elapsed),
        .total_elapsed_with_isr(total_elapsed_with_isr)
    );

    ipc_pkg::ctl_t chan_ctl [NCH];
    ipc_pkg::stat_t chan_stat [NCH];
    logic [ipc_pkg::TS_W-1:0] isr_total;
    logic [ipc_pkg::MASK_W-1:0] isr_mask;

    pending_t pending_q [$];
    chan_stats_t stats_due [$];
    int n_words;
    int n_taken;
    int n_fail;
    int quiet;
    bit took;

    int burst_left;
    int gap_left;
    int settle;

    bit gen_open [NCH];
    logic [ipc_pkg::TS_W-1:0] gen_clock;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic chan_stats_t profile_event(input logic [ipc_pkg::CMD_W-1:0] cmd,
                                                  input logic [ipc_pkg::CH_W-1:0] ch,
                                                  input logic [ipc_pkg::TS_W-1:0] ts);
        chan_stats_t r;
        logic [ipc_pkg::TS_W-1:0] span;
        logic [ipc_pkg::TS_W-1:0] net;
        r = '0;
        if (cmd == ipc_pkg::CMD_ENTER)
        begin
            if (!chan_ctl[ch].busy)
            begin
                chan_ctl[ch].start_time = ts;
                chan_ctl[ch].isr_start = isr_total;
                chan_ctl[ch].busy = 1'b1;
            end
            else
            begin
                chan_ctl[ch].error_count = chan_ctl[ch].error_count + 32'd1;
                r.status = 1'b1;
            end
        end
        else if (cmd == ipc_pkg::CMD_EXIT)
        begin
            if (chan_ctl[ch].busy)
            begin
                span = ts - chan_ctl[ch].start_time;
                if (span > chan_stat[ch].max_elapsed_with_isr)
                    chan_stat[ch].max_elapsed_with_isr = span;
                chan_stat[ch].total_elapsed_with_isr =
                    chan_stat[ch].total_elapsed_with_isr
                    + {{(ipc_pkg::CNT_W-ipc_pkg::TS_W){1'b0}}, span};
                net = span - (isr_total - chan_ctl[ch].isr_start);
                if (isr_mask[ch])
                    isr_total = isr_total + net;
                if (net < chan_stat[ch].min_elapsed)
                    chan_stat[ch].min_elapsed = net;
                if (net > chan_stat[ch].max_elapsed)
                    chan_stat[ch].max_elapsed = net;
                chan_stat[ch].total_elapsed =
                    chan_stat[ch].total_elapsed
                    + {{(ipc_pkg::CNT_W-ipc_pkg::TS_W){1'b0}}, net};
                chan_stat[ch].call_count = chan_stat[ch].call_count + 64'd1;
                chan_ctl[ch].busy = 1'b0;
            end
            else
            begin
                chan_ctl[ch].error_count = chan_ctl[ch].error_count + 32'd1;
                r.status = 1'b1;
            end
        end
        else if (cmd == ipc_pkg::CMD_CLEAR)
        begin
            foreach (chan_stat[k])
                chan_stat[k] = ipc_pkg::STAT_RESET;
        end
        r.running = chan_ctl[ch].busy;
        r.call_count = chan_stat[ch].call_count;
        r.error_count = chan_ctl[ch].error_count;
        r.min_elapsed = chan_stat[ch].min_elapsed;
        r.max_elapsed = chan_stat[ch].max_elapsed;
        r.max_elapsed_with_isr = chan_stat[ch].max_elapsed_with_isr;
        r.total_elapsed = chan_stat[ch].total_elapsed;
        r.total_elapsed_with_isr = chan_stat[ch].total_elapsed_with_isr;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [ipc_pkg::CNT_W-1:0] want,
                               input logic [ipc_pkg::CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    task automatic add_word(input logic [ipc_pkg::CMD_W-1:0] cmd,
                            input logic [ipc_pkg::CH_W-1:0] ch,
                            input logic [ipc_pkg::TS_W-1:0] ts);
        pending_t p;
        p.is_cfg = 1'b0;
        p.cmd = cmd;
        p.ch = ch;
        p.ts = ts;
        p.mask = '0;
        pending_q.push_back(p);
        n_words++;
    endtask

    task automatic add_mask(input logic [ipc_pkg::MASK_W-1:0] mask);
        pending_t p;
        p.is_cfg = 1'b1;
        p.cmd = ipc_pkg::CMD_READ;
        p.ch = '0;
        p.ts = '0;
        p.mask = mask;
        pending_q.push_back(p);
    endtask

    // Mostly matched enter and exit pairs on a slowly advancing clock, with some noise.
    task automatic add_random_words(input int count);
        int roll;
        logic [ipc_pkg::CH_W-1:0] ch;
        logic [ipc_pkg::CMD_W-1:0] cmd;
        logic [ipc_pkg::TS_W-1:0] ts;
        for (int i = 0; i < count; i++)
        begin
            ch = ipc_pkg::CH_W'($urandom_range(0, NCH - 1));
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = ipc_pkg::CMD_CLEAR;
            else if (roll < 13)
                cmd = ipc_pkg::CMD_READ;
            else if (roll < 21)
                cmd = ($urandom_range(0, 1) != 0) ? ipc_pkg::CMD_EXIT : ipc_pkg::CMD_ENTER;
            else
                cmd = gen_open[ch] ? ipc_pkg::CMD_EXIT : ipc_pkg::CMD_ENTER;
            if ($urandom_range(0, 99) < 5)
                ts = $urandom;
            else
            begin
                gen_clock = gen_clock + $urandom_range(0, 300);
                ts = gen_clock;
            end
            if (cmd == ipc_pkg::CMD_ENTER)
                gen_open[ch] = 1'b1;
            else if (cmd == ipc_pkg::CMD_EXIT)
                gen_open[ch] = 1'b0;
            add_word(cmd, ch, ts);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        chan_stats_t want;
        if (rst_n)
        begin
            took = start && !busy;
            if (done)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected none actual %0h",
                             $time, call_count);
                    n_fail++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("status", ipc_pkg::CNT_W'(want.status),
                                ipc_pkg::CNT_W'(status));
                    check_field("running", ipc_pkg::CNT_W'(want.running),
                                ipc_pkg::CNT_W'(running));
                    check_field("call_count", want.call_count, call_count);
                    check_field("error_count", ipc_pkg::CNT_W'(want.error_count),
                                ipc_pkg::CNT_W'(error_count));
                    check_field("min_elapsed", ipc_pkg::CNT_W'(want.min_elapsed),
                                ipc_pkg::CNT_W'(min_elapsed));
                    check_field("max_elapsed", ipc_pkg::CNT_W'(want.max_elapsed),
                                ipc_pkg::CNT_W'(max_elapsed));
                    check_field("max_elapsed_with_isr",
                                ipc_pkg::CNT_W'(want.max_elapsed_with_isr),
                                ipc_pkg::CNT_W'(max_elapsed_with_isr));
                    check_field("total_elapsed", want.total_elapsed, total_elapsed);
                    check_field("total_elapsed_with_isr", want.total_elapsed_with_isr,
                                total_elapsed_with_isr);
                end
            end
            if (cfg_wr_en)
                isr_mask = cfg_wr_data;
            if (took)
            begin
                stats_due.push_back(profile_event(command, channel, timestamp));
                n_taken++;
            end
            if (took || done || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        else
            took = 1'b0;
    end

    always @(negedge clk)
    begin : driver
        pending_t p;
        logic nxt_start;
        logic nxt_wr;
        nxt_start = start;
        nxt_wr = 1'b0;
        if (!rst_n)
            nxt_start = 1'b0;
        else if (!start || took)
        begin
            nxt_start = 1'b0;
            if (pending_q.size() != 0)
            begin
                if (pending_q[0].is_cfg)
                begin
                    if (stats_due.size() == 0 && !busy)
                        settle++;
                    else
                        settle = 0;
                    if (settle >= 4)
                    begin
                        p = pending_q.pop_front();
                        nxt_wr = 1'b1;
                        cfg_wr_data <= p.mask;
                        settle = 0;
                    end
                end
                else if (gap_left != 0)
                    gap_left--;
                else
                begin
                    p = pending_q.pop_front();
                    nxt_start = 1'b1;
                    command <= p.cmd;
                    channel <= p.ch;
                    timestamp <= p.ts;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            burst_left = 40;
                            gap_left = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 16);
                            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
                        end
                    end
                    else
                        burst_left--;
                end
            end
        end
        start <= nxt_start;
        cfg_wr_en <= nxt_wr;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        command = ipc_pkg::CMD_READ;
        channel = '0;
        timestamp = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        n_words = 0;
        n_taken = 0;
        n_fail = 0;
        quiet = 0;
        took = 1'b0;
        burst_left = 1;
        gap_left = 0;
        settle = 0;
        isr_total = '0;
        isr_mask = '0;
        gen_clock = '0;
        foreach (chan_ctl[k])
        begin
            chan_ctl[k] = ipc_pkg::CTL_RESET;
            chan_stat[k] = ipc_pkg::STAT_RESET;
            gen_open[k] = 1'b0;
        end

        add_word(ipc_pkg::CMD_READ, 4'd0, 32'd0);
        add_word(ipc_pkg::CMD_EXIT, 4'd3, 32'd5);
        add_word(ipc_pkg::CMD_ENTER, 4'd0, 32'd0);
        add_word(ipc_pkg::CMD_ENTER, 4'd0, 32'd7);
        add_word(ipc_pkg::CMD_EXIT, 4'd0, 32'hFFFF_FFFF);
        add_word(ipc_pkg::CMD_ENTER, 4'd15, 32'hFFFF_FFF0);
        add_word(ipc_pkg::CMD_EXIT, 4'd15, 32'd10);
        add_word(ipc_pkg::CMD_ENTER, 4'd5, 32'd100);
        add_word(ipc_pkg::CMD_EXIT, 4'd5, 32'd100);
        add_word(ipc_pkg::CMD_READ, 4'd15, 32'hFFFF_FFFF);
        add_word(ipc_pkg::CMD_ENTER, 4'd7, 32'd1);
        add_word(ipc_pkg::CMD_CLEAR, 4'd7, 32'd2);
        add_word(ipc_pkg::CMD_READ, 4'd7, 32'd3);
        add_word(ipc_pkg::CMD_EXIT, 4'd7, 32'd50);
        add_mask(16'h0003);
        add_word(ipc_pkg::CMD_ENTER, 4'd9, 32'd1000);
        add_word(ipc_pkg::CMD_ENTER, 4'd1, 32'd1100);
        add_word(ipc_pkg::CMD_ENTER, 4'd0, 32'd1120);
        add_word(ipc_pkg::CMD_EXIT, 4'd0, 32'd1130);
        add_word(ipc_pkg::CMD_EXIT, 4'd1, 32'd1150);
        add_word(ipc_pkg::CMD_EXIT, 4'd9, 32'd1400);
        add_word(ipc_pkg::CMD_READ, 4'd9, 32'd0);
        add_word(ipc_pkg::CMD_READ, 4'd1, 32'd0);

        add_mask(16'hFFFF);
        add_random_words(500);
        add_mask(ipc_pkg::MASK_W'($urandom));
        add_random_words(500);
        add_mask(16'h0000);
        add_random_words(500);
        add_mask(16'h8001);
        add_random_words(500);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (!(n_taken == n_words && stats_due.size() == 0) && quiet < QUIET_LIMIT)
            @(negedge clk);
        if (quiet >= QUIET_LIMIT)
        begin
            $display("interval_profiler_channels_top: mismatch");
            $finish;
        end
        else
        begin
            repeat (10) @(negedge clk);
            if (n_fail == 0)
                $display("interval_profiler_channels_top: match");
            else
                $display("interval_profiler_channels_top: mismatch");
            $finish;
        end
    end

endmodule

`default_nettype wire
